// ===== hdl/bcsa_pkg.sv =====
// ============================================================================
// bcsa_pkg: shared types and constants for the contour signed-area block
// Item formats, mode codes and the exact cross-product helper.
// ============================================================================
package bcsa_pkg;

   // Coordinate and accumulator widths
   localparam int COORD_BITS = 20;
   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int ACC_BITS   = 64;
   localparam int MODE_BITS  = 3;

   // Path item modes
   localparam logic [MODE_BITS-1:0] MODE_MOVE  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_LINE  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_QUAD  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_CUBIC = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_CLOSE = 3'd4;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;

   // Input item
   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      coord_type            pt_a_x;
      coord_type            pt_a_y;
      coord_type            pt_b_x;
      coord_type            pt_b_y;
      coord_type            pt_c_x;
      coord_type            pt_c_y;
   } req_type;

   // Result item
   typedef struct packed {
      acc_type scaled_area;
      logic    area_nonnegative;
      logic    saturated;
   } rsp_type;

   // Stage 1: segment with its start point resolved
   typedef struct packed {
      logic [MODE_BITS-1:0] op;
      coord_type            p0_x;
      coord_type            p0_y;
      coord_type            a_x;
      coord_type            a_y;
      coord_type            b_x;
      coord_type            b_y;
      coord_type            c_x;
      coord_type            c_y;
   } seg_type;

   // Stage 2: the six cross products a segment can need
   typedef struct packed {
      logic [MODE_BITS-1:0] op;
      cross_type            c0a;
      cross_type            c0b;
      cross_type            c0c;
      cross_type            cab;
      cross_type            cac;
      cross_type            cbc;
   } crs_type;

   // Stage 3: scaled area term
   typedef struct packed {
      logic [MODE_BITS-1:0] op;
      acc_type              term;
   } trm_type;

   // cross(p, q) = p.x*q.y - q.x*p.y, exact
   function automatic cross_type cross_f(input coord_type px, input coord_type py,
                                         input coord_type qx, input coord_type qy);
      logic signed [PROD_BITS-1:0] m0;
      logic signed [PROD_BITS-1:0] m1;
      m0 = px * qy;
      m1 = qx * py;
      return CROSS_BITS'(m0) - CROSS_BITS'(m1);
   endfunction

endpackage

// ===== hdl/bezier_contour_signed_area_top.sv =====
// ============================================================================
// bezier_contour_signed_area_top: streaming signed area of a Bezier contour
// Accumulates exact Green's-theorem area terms of move/line/quad/cubic/close
// items and emits sixty times the contour area on close.
// ============================================================================
// Takes one path item per clock cycle, sustained while no waiting result
// holds the pipeline. An item passes through three stages (segment register,
// cross-product register, area-term register) and is folded into the 64-bit
// saturating accumulator as it leaves the last one; a close item's result is
// registered in the output register as the close leaves it. The accumulator's
// single add-and-saturate per cycle is the loop that sets this rate. A waiting
// result holds a close item in the last stage; the items behind it back up
// until the input stalls. Modes five to seven are accepted and dropped.
module bezier_contour_signed_area_top
   import bcsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Contour tracking at accept time
   coord_type start_x_ff, start_y_ff, last_x_ff, last_y_ff;
   coord_type start_x_in, start_y_in, last_x_in, last_y_in;

   // Pipeline stages
   logic    s1_vld_ff, s1_vld_in;
   seg_type s1_ff, s1_in;
   logic    s2_vld_ff, s2_vld_in;
   crs_type s2_ff, s2_in;
   logic    s3_vld_ff, s3_vld_in;
   trm_type s3_ff, s3_in;

   // Accumulator and output register
   acc_type acc_ff, acc_in;
   logic    clip_ff, clip_in;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   logic    req_take, take1, take2, take3, out_free;
   logic    ovf;
   acc_type acc_sat;
   logic signed [ACC_BITS:0] sum_wide;

   // Flow control: stages collapse bubbles; only close needs the output slot
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign take3     = s3_vld_ff && ((s3_ff.op != MODE_CLOSE) || out_free);
   assign take2     = s2_vld_ff && (!s3_vld_ff || take3);
   assign take1     = s1_vld_ff && (!s2_vld_ff || take2);
   assign req_ready = !s1_vld_ff || take1;
   assign req_take  = req_valid && req_ready;

   // Start and previous endpoint, resolved per item
   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      if (req_take) begin
         case (req_data.mode)
            MODE_MOVE: begin
               start_x_in = req_data.pt_a_x;
               start_y_in = req_data.pt_a_y;
               last_x_in  = req_data.pt_a_x;
               last_y_in  = req_data.pt_a_y;
            end
            MODE_LINE: begin
               last_x_in = req_data.pt_a_x;
               last_y_in = req_data.pt_a_y;
            end
            MODE_QUAD: begin
               last_x_in = req_data.pt_b_x;
               last_y_in = req_data.pt_b_y;
            end
            MODE_CUBIC: begin
               last_x_in = req_data.pt_c_x;
               last_y_in = req_data.pt_c_y;
            end
            MODE_CLOSE: begin
               last_x_in = start_x_ff;
               last_y_in = start_y_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Stage 1: segment register; close uses the start point as its end
   always_comb begin
      s1_vld_in = s1_vld_ff;
      s1_in     = s1_ff;
      if (req_ready) begin
         s1_vld_in = req_take && (req_data.mode <= MODE_CLOSE);
         s1_in.op   = req_data.mode;
         s1_in.p0_x = last_x_ff;
         s1_in.p0_y = last_y_ff;
         s1_in.a_x  = (req_data.mode == MODE_CLOSE) ? start_x_ff : req_data.pt_a_x;
         s1_in.a_y  = (req_data.mode == MODE_CLOSE) ? start_y_ff : req_data.pt_a_y;
         s1_in.b_x  = req_data.pt_b_x;
         s1_in.b_y  = req_data.pt_b_y;
         s1_in.c_x  = req_data.pt_c_x;
         s1_in.c_y  = req_data.pt_c_y;
      end
   end

   // Stage 2: cross products
   always_comb begin
      s2_vld_in = s2_vld_ff;
      s2_in     = s2_ff;
      if (!s2_vld_ff || take2) begin
         s2_vld_in = take1;
         s2_in.op  = s1_ff.op;
         s2_in.c0a = cross_f(s1_ff.p0_x, s1_ff.p0_y, s1_ff.a_x, s1_ff.a_y);
         s2_in.c0b = cross_f(s1_ff.p0_x, s1_ff.p0_y, s1_ff.b_x, s1_ff.b_y);
         s2_in.c0c = cross_f(s1_ff.p0_x, s1_ff.p0_y, s1_ff.c_x, s1_ff.c_y);
         s2_in.cab = cross_f(s1_ff.a_x, s1_ff.a_y, s1_ff.b_x, s1_ff.b_y);
         s2_in.cac = cross_f(s1_ff.a_x, s1_ff.a_y, s1_ff.c_x, s1_ff.c_y);
         s2_in.cbc = cross_f(s1_ff.b_x, s1_ff.b_y, s1_ff.c_x, s1_ff.c_y);
      end
   end

   // Stage 3: weighted term, 30x the doubled area of the segment
   always_comb begin
      acc_type e0a, e0b, e0c, eab, eac, ebc, cub;
      e0a = ACC_BITS'(s2_ff.c0a);
      e0b = ACC_BITS'(s2_ff.c0b);
      e0c = ACC_BITS'(s2_ff.c0c);
      eab = ACC_BITS'(s2_ff.cab);
      eac = ACC_BITS'(s2_ff.cac);
      ebc = ACC_BITS'(s2_ff.cbc);
      cub = e0a * 64'sd6 + e0b * 64'sd3 + e0c + eab * 64'sd3 + eac * 64'sd3
            + ebc * 64'sd6;
      s3_vld_in = s3_vld_ff;
      s3_in     = s3_ff;
      if (!s3_vld_ff || take3) begin
         s3_vld_in = take2;
         s3_in.op  = s2_ff.op;
         case (s2_ff.op)
            MODE_LINE, MODE_CLOSE: s3_in.term = e0a * 64'sd30;
            MODE_QUAD:  s3_in.term = (e0a + eab) * 64'sd20 + e0b * 64'sd10;
            MODE_CUBIC: s3_in.term = cub * 64'sd3;
            default:    s3_in.term = '0;
         endcase
      end
   end

   // Saturating accumulate and result register
   assign sum_wide = {acc_ff[ACC_BITS-1], acc_ff} + {s3_ff.term[ACC_BITS-1], s3_ff.term};
   assign ovf      = sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1];
   assign acc_sat  = ovf ? (sum_wide[ACC_BITS] ? ACC_MIN : ACC_MAX)
                         : sum_wide[ACC_BITS-1:0];

   always_comb begin
      acc_in     = acc_ff;
      clip_in    = clip_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      rsp_in     = rsp_ff;
      if (take3) begin
         case (s3_ff.op)
            MODE_MOVE: begin
               acc_in  = '0;
               clip_in = 1'b0;
            end
            MODE_CLOSE: begin
               rsp_vld_in              = 1'b1;
               rsp_in.scaled_area      = acc_sat;
               rsp_in.area_nonnegative = !acc_sat[ACC_BITS-1];
               rsp_in.saturated        = clip_ff || ovf;
               acc_in                  = '0;
               clip_in                 = 1'b0;
            end
            default: begin
               acc_in  = acc_sat;
               clip_in = clip_ff || ovf;
            end
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         acc_ff     <= '0;
         clip_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         acc_ff     <= acc_in;
         clip_ff    <= clip_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // A close item never leaves while the output slot is occupied
   a_close_holds: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff && (s3_ff.op == MODE_CLOSE) && rsp_vld_ff && !rsp_ready |=> s3_vld_ff)
      else $error("close item dropped while result stalled");

   // A new result comes only from a close leaving the last stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !$past(rsp_vld_ff && !rsp_ready) |->
         $past(take3 && (s3_ff.op == MODE_CLOSE)))
      else $error("result without close item");

   // Move and close leave a cleared accumulator
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      take3 && ((s3_ff.op == MODE_MOVE) || (s3_ff.op == MODE_CLOSE)) |=>
         (acc_ff == '0) && !clip_ff)
      else $error("accumulator not cleared");

   // Sign flag agrees with the area
   a_sign_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.area_nonnegative == !rsp_ff.scaled_area[ACC_BITS-1]))
      else $error("area sign flag mismatch");
`endif

endmodule

// ===== dv/bcsa_area_checker.sv =====
// ============================================================================
// bcsa_area_checker: result predictor and scoreboard for the contour area block
// Watches both item channels, traces every accepted path item through its own
// copy of the contour state and compares each result item field by field.
// ============================================================================
module bcsa_area_checker
   import bcsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_count
);

   // Contour state as seen by the predictor
   coord_type start_x;
   coord_type start_y;
   coord_type last_x;
   coord_type last_y;
   acc_type   area_sum;
   logic      clipped;

   // Areas of closed contours still on their way out
   rsp_type area_expect_q[$];

   function automatic longint cross_of(input longint px, py, qx, qy);
      return px * qy - qx * py;
   endfunction

   // Saturating add into the area accumulator
   task automatic add_term(input longint term);
      logic signed [ACC_BITS:0] wide;
      wide = {area_sum[ACC_BITS-1], area_sum} + {term[63], term};
      if (wide[ACC_BITS] != wide[ACC_BITS-1]) begin
         area_sum = wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
         clipped  = 1'b1;
      end else begin
         area_sum = wide[ACC_BITS-1:0];
      end
   endtask

   // Fold one path item into the contour; a close queues its area
   task automatic fold_path_item(input req_type item);
      longint  px, py, ax, ay, bx, by, cx, cy;
      longint  tri_sum, sum6;
      rsp_type done;
      px = last_x;
      py = last_y;
      ax = item.pt_a_x;
      ay = item.pt_a_y;
      bx = item.pt_b_x;
      by = item.pt_b_y;
      cx = item.pt_c_x;
      cy = item.pt_c_y;
      case (item.mode)
         MODE_MOVE: begin
            start_x  = item.pt_a_x;
            start_y  = item.pt_a_y;
            last_x   = item.pt_a_x;
            last_y   = item.pt_a_y;
            area_sum = '0;
            clipped  = 1'b0;
         end
         MODE_LINE: begin
            add_term(30 * cross_of(px, py, ax, ay));
            last_x = item.pt_a_x;
            last_y = item.pt_a_y;
         end
         MODE_QUAD: begin
            tri_sum = cross_of(px, py, ax, ay) + cross_of(ax, ay, bx, by)
                    + cross_of(bx, by, px, py);
            add_term(30 * cross_of(px, py, bx, by) + 20 * tri_sum);
            last_x = item.pt_b_x;
            last_y = item.pt_b_y;
         end
         MODE_CUBIC: begin
            sum6 = 6 * cross_of(px, py, ax, ay) + 3 * cross_of(px, py, bx, by)
                 + cross_of(px, py, cx, cy) + 3 * cross_of(ax, ay, bx, by)
                 + 3 * cross_of(ax, ay, cx, cy) + 6 * cross_of(bx, by, cx, cy);
            add_term(3 * sum6);
            last_x = item.pt_c_x;
            last_y = item.pt_c_y;
         end
         MODE_CLOSE: begin
            add_term(30 * cross_of(px, py, start_x, start_y));
            done.scaled_area      = area_sum;
            done.area_nonnegative = (area_sum >= 0);
            done.saturated        = clipped;
            area_expect_q         = {area_expect_q, done};
            area_sum = '0;
            clipped  = 1'b0;
            last_x   = start_x;
            last_y   = start_y;
         end
         default: ; // spare modes are dropped
      endcase
   endtask

   // Compare results first, then trace the new path item
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         start_x  = '0;
         start_y  = '0;
         last_x   = '0;
         last_y   = '0;
         area_sum = '0;
         clipped  = 1'b0;
         area_expect_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (area_expect_q.size() == 0) begin
               $error("unexpected result item: scaled_area %0d", rsp_data.scaled_area);
               mismatch_count++;
            end else begin
               want = area_expect_q.pop_front();
               if (rsp_data.scaled_area !== want.scaled_area) begin
                  $error("scaled_area expected %0d actual %0d",
                         want.scaled_area, rsp_data.scaled_area);
                  mismatch_count++;
               end
               if (rsp_data.area_nonnegative !== want.area_nonnegative) begin
                  $error("area_nonnegative expected %0b actual %0b",
                         want.area_nonnegative, rsp_data.area_nonnegative);
                  mismatch_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated expected %0b actual %0b",
                         want.saturated, rsp_data.saturated);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) fold_path_item(req_data);
      end
      pending_count = area_expect_q.size();
   end

endmodule

// ===== dv/tb_bezier_contour_signed_area_top.sv =====
// ============================================================================
// tb_bezier_contour_signed_area_top: testbench for the contour area block
// Drives directed and random path items, two long contours around the
// coordinate box and a long result back-pressure stretch; the area checker
// scores every result.
// ============================================================================
module tb_bezier_contour_signed_area_top;
   import bcsa_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;
   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam int RANDOM_ITEMS   = 1350;
   localparam int QUIET_ITEMS    = 200;   // tail of the run without idling
   localparam int HOLD_AT_ITEM   = 300;
   localparam int HOLD_CYCLES    = 300;
   localparam int BOX_LOOPS      = 50;    // corner loops per long contour
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 12;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int error_count;
   int pending_count;
   int path_items_sent;
   int stalled_cycles;
   bit stall_enable;
   bit hold_request;

   always #1 clock = ~clock;

   bezier_contour_signed_area_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   bcsa_area_checker area_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (error_count),
      .pending_count  (pending_count)
   );

   function automatic req_type make_item(input logic [MODE_BITS-1:0] mode,
                                         input coord_type ax, ay, bx, by, cx, cy);
      req_type item;
      item.mode   = mode;
      item.pt_a_x = ax;
      item.pt_a_y = ay;
      item.pt_b_x = bx;
      item.pt_b_y = by;
      item.pt_c_x = cx;
      item.pt_c_y = cy;
      return item;
   endfunction

   // Mostly full range, some small values, some extremes
   function automatic coord_type rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return coord_type'($urandom);
      if (pick < 8) return coord_type'(int'($urandom_range(0, 255)) - 128);
      case ($urandom_range(0, 4))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return '0;
         3:       return '1;
         default: return coord_type'(1);
      endcase
   endfunction

   function automatic req_type rand_item(input logic [MODE_BITS-1:0] mode);
      return make_item(mode, rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord());
   endfunction

   // Offer one item at the falling edge and hold it until accepted
   task automatic push_item(input req_type item);
      if (stall_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (item.mode <= MODE_CLOSE) path_items_sent++;
   endtask

   // Well-formed contour: usually a move, some segments, then close
   task automatic push_contour();
      int segs;
      segs = $urandom_range(0, 8);
      if ($urandom_range(0, 7) != 0) push_item(rand_item(MODE_MOVE));
      repeat (segs) push_item(rand_item(MODE_BITS'($urandom_range(MODE_LINE, MODE_CUBIC))));
      push_item(rand_item(MODE_CLOSE));
   endtask

   // Two cubics hugging the corners of the full coordinate box
   task automatic trace_box_loop(input bit ccw);
      if (ccw) begin
         push_item(make_item(MODE_CUBIC, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                             COORD_MAX, COORD_MAX));
         push_item(make_item(MODE_CUBIC, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                             COORD_MIN, COORD_MIN));
      end else begin
         push_item(make_item(MODE_CUBIC, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                             COORD_MAX, COORD_MAX));
         push_item(make_item(MODE_CUBIC, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                             COORD_MIN, COORD_MIN));
      end
   endtask

   // Long contour of box loops, then one loop the other way round
   task automatic push_clipping_contour(input bit ccw);
      push_item(make_item(MODE_MOVE, COORD_MIN, COORD_MIN, rand_coord(), rand_coord(),
                          rand_coord(), rand_coord()));
      repeat (BOX_LOOPS) trace_box_loop(ccw);
      trace_box_loop(!ccw);
      push_item(rand_item(MODE_CLOSE));
   endtask

   // Result side: random stall bursts, one long hold when asked
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (stall_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      bit hold_issued;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      stall_enable    = 1'b1;
      hold_request    = 1'b0;
      hold_issued     = 1'b0;
      path_items_sent = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // close and a segment straight out of reset use the origin as start
      push_item(rand_item(MODE_CLOSE));
      push_item(make_item(MODE_LINE, COORD_MAX, COORD_MAX, rand_coord(), rand_coord(),
                          rand_coord(), rand_coord()));
      push_item(make_item(MODE_CUBIC, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                          COORD_MIN, COORD_MIN));
      push_item(rand_item(MODE_CLOSE));
      // spare modes are dropped
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
         push_item(rand_item(MODE_SPARE_LO + 3'(m - MODE_SPARE_LO)));
      // every segment kind at the coordinate extremes
      push_item(make_item(MODE_MOVE, COORD_MAX, COORD_MIN, '0, '0, '0, '0));
      push_item(make_item(MODE_LINE, COORD_MAX, COORD_MAX, '1, '1, '1, '1));
      push_item(make_item(MODE_QUAD, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MAX));
      push_item(make_item(MODE_CUBIC, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MAX));
      push_item(rand_item(MODE_CLOSE));
      // back-to-back close, then segments restart from the same start point
      push_item(rand_item(MODE_CLOSE));
      push_item(make_item(MODE_LINE, COORD_MIN, COORD_MAX, '0, '0, '0, '0));
      push_item(rand_item(MODE_CLOSE));
      // a move abandons the open contour
      push_item(make_item(MODE_MOVE, coord_type'(1), coord_type'(1), '0, '0, '0, '0));
      push_item(make_item(MODE_LINE, coord_type'(5), coord_type'(9), '0, '0, '0, '0));
      push_item(make_item(MODE_MOVE, COORD_MIN, COORD_MIN, '0, '0, '0, '0));
      push_item(make_item(MODE_LINE, COORD_MAX, COORD_MIN, '0, '0, '0, '0));
      push_item(make_item(MODE_LINE, COORD_MAX, COORD_MAX, '0, '0, '0, '0));
      push_item(rand_item(MODE_CLOSE));
      // clockwise triangle gives a negative area
      push_item(make_item(MODE_MOVE, '0, '0, '0, '0, '0, '0));
      push_item(make_item(MODE_LINE, '0, COORD_MAX, '0, '0, '0, '0));
      push_item(make_item(MODE_LINE, COORD_MAX, '0, '0, '0, '0, '0));
      push_item(rand_item(MODE_CLOSE));

      // long contours of both windings, back to back with no idling
      stall_enable = 1'b0;
      push_clipping_contour(1'b1);
      push_clipping_contour(1'b0);

      // random contours mixed with noise
      stall_enable    = 1'b1;
      path_items_sent = 0;
      while (path_items_sent < RANDOM_ITEMS) begin
         if (path_items_sent >= RANDOM_ITEMS - QUIET_ITEMS) stall_enable = 1'b0;
         else if ($urandom_range(0, 9) == 0) stall_enable = !stall_enable;
         if (!hold_issued && path_items_sent >= HOLD_AT_ITEM) begin
            hold_request = 1'b1;
            hold_issued  = 1'b1;
         end
         if ($urandom_range(0, 4) != 0) push_contour();
         else push_item(rand_item(MODE_BITS'($urandom_range(MODE_MOVE, MODE_SPARE_HI))));
      end
      req_valid <= 1'b0;

      // drain outstanding results, then allow for stray ones
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
